// ===== hw/rtl/dtsd_pkg.sv =====
// ----------------------------------------------------------------------------
// dtsd_pkg
// Shared constants and types of the dual-threshold spike detector.
// ----------------------------------------------------------------------------
package dtsd_pkg;

  localparam int unsigned WINDOW    = 32;
  localparam int unsigned HISTORY   = 64;
  localparam int unsigned PENDING   = 16;

  localparam int unsigned BEFORE    = WINDOW / 4 + 1;
  localparam int unsigned SNIP_FULL = WINDOW / 4 + (3 * WINDOW) / 4;
  localparam int unsigned MAX_OUT   = 32;
  localparam int unsigned SNIP      = (SNIP_FULL < MAX_OUT) ? SNIP_FULL : MAX_OUT;
  localparam int unsigned READY     = (3 * WINDOW) / 4 - 2;

  localparam int unsigned HistAw = $clog2(HISTORY);
  localparam int unsigned PendAw = $clog2(PENDING);
  localparam int unsigned CntW   = $clog2(PENDING + 1);
  localparam int unsigned FillW  = $clog2(HISTORY + 1);
  localparam int unsigned AgeW   = $clog2(WINDOW);

  localparam logic signed [15:0] UPPER_RST = 16'sd1000;
  localparam logic signed [15:0] LOWER_RST = -16'sd1000;
  localparam logic [15:0]        SKIP_RST  = 16'd0;

  typedef enum logic [1:0] {
    CFG_UPPER = 2'd0,
    CFG_LOWER = 2'd1,
    CFG_SKIP  = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_e;

  // one snippet result handed from the sequencer to the output register
  typedef struct packed {
    logic               load;
    logic [31:0]        spike_at;
    logic signed [15:0] wave_sample;
    logic [4:0]         wave_slot;
    logic               last;
  } out_req_t;

endpackage

// ===== hw/rtl/dtsd_ram.sv =====
// ----------------------------------------------------------------------------
// dtsd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dtsd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dtsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtsd_ctrl
// Sequencer: history write, threshold search, peak queue, snippet walk.
// ----------------------------------------------------------------------------
module dtsd_ctrl import dtsd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic signed [15:0] sample_i,
  output logic               busy_o,
  input  logic signed [15:0] upper_i,
  input  logic signed [15:0] lower_i,
  input  logic [15:0]        skip_i,
  output logic               h_we_o,
  output logic [HistAw-1:0]  h_waddr_o,
  output logic [15:0]        h_wdata_o,
  output logic               h_re_o,
  output logic [HistAw-1:0]  h_raddr_o,
  input  logic [15:0]        h_rdata_i,
  output logic               p_we_o,
  output logic [PendAw-1:0]  p_waddr_o,
  output logic [31:0]        p_wdata_o,
  output logic               p_re_o,
  output logic [PendAw-1:0]  p_raddr_o,
  input  logic [31:0]        p_rdata_i,
  input  logic               out_free_i,
  output out_req_t           out_req_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_S_RD, ST_S_EV, ST_S_END, ST_PEEK, ST_PCHK, ST_E_RD, ST_E_WR
  } state_e;

  state_e             state_q, state_d;
  logic [31:0]        pos_q, pos_d, t_q, t_d, resume_q, resume_d;
  logic [HistAw-1:0]  head_q, head_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic signed [15:0] s_q, s_d, best_q, best_d;
  logic [AgeW-1:0]    a_q, a_d;
  logic               found_q, found_d, zero_q, zero_d;
  logic [31:0]        peak_q, peak_d, d_q, d_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [PendAw-1:0]  rd_q, rd_d;
  logic [4:0]         j_q, j_d;

  logic [31:0]        diff, age, gap;
  logic [HistAw:0]    hsum, hage;
  logic [CntW:0]      psum;
  logic signed [15:0] v;

  // ring index helper
  function automatic logic [HistAw-1:0] hist_idx(logic [HistAw-1:0] head,
                                                 logic [HistAw:0] back);
    logic [HistAw+1:0] x;
    x = {2'b00, head} + (HistAw+2)'(HISTORY) - {1'b0, back};
    if (x >= (HistAw+2)'(HISTORY)) begin
      x = x - (HistAw+2)'(HISTORY);
    end
    return x[HistAw-1:0];
  endfunction

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    t_d      = t_q;
    resume_d = resume_q;
    head_d   = head_q;
    fill_d   = fill_q;
    s_d      = s_q;
    best_d   = best_q;
    a_d      = a_q;
    found_d  = found_q;
    zero_d   = zero_q;
    peak_d   = peak_q;
    d_d      = d_q;
    cnt_d    = cnt_q;
    rd_d     = rd_q;
    j_d      = j_q;

    h_we_o    = 1'b0;
    h_waddr_o = '0;
    h_wdata_o = sample_i;
    h_re_o    = 1'b0;
    h_raddr_o = hist_idx(head_q, {{(HistAw+1-AgeW){1'b0}}, a_q});
    p_we_o    = 1'b0;
    p_wdata_o = peak_q;
    p_re_o    = 1'b0;
    p_raddr_o = rd_q;
    out_req_o = '0;

    diff = pos_q - resume_q;
    hsum = {1'b0, head_q} + 1'b1;
    psum = {1'b0, cnt_q} + {{(CntW+1-PendAw){1'b0}}, rd_q};
    if (psum >= (CntW+1)'(PENDING)) begin
      psum = psum - (CntW+1)'(PENDING);
    end
    p_waddr_o = psum[PendAw-1:0];

    age  = d_q + 32'(BEFORE) - {27'd0, j_q};
    hage = age[HistAw:0];
    gap  = t_q - p_rdata_i;
    v    = ({{(32-FillW){1'b0}}, fill_q} <= {{(32-AgeW){1'b0}}, a_q})
           ? 16'sd0 : $signed(h_rdata_i);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (hsum >= (HistAw+1)'(HISTORY)) begin
            hsum = '0;
          end
          h_we_o    = 1'b1;
          h_waddr_o = hsum[HistAw-1:0];
          head_d    = hsum[HistAw-1:0];
          if (fill_q != FillW'(HISTORY)) begin
            fill_d = fill_q + 1'b1;
          end
          t_d     = pos_q;
          pos_d   = pos_q + 1'b1;
          s_d     = sample_i;
          found_d = 1'b0;
          a_d     = (diff < 32'(WINDOW - 1)) ? diff[AgeW-1:0] : AgeW'(WINDOW - 1);
          state_d = (sample_i < lower_i) ? ST_S_RD : ST_PEEK;
        end
      end
      ST_S_RD: begin
        h_re_o  = 1'b1;
        state_d = ST_S_EV;
      end
      ST_S_EV: begin
        // oldest upper crossing opens the peak search; later larger values win
        if (!found_q) begin
          if ((t_q - {{(32-AgeW){1'b0}}, a_q}) >= {16'd0, skip_i} && v > upper_i) begin
            found_d = 1'b1;
            peak_d  = t_q - {{(32-AgeW){1'b0}}, a_q};
            best_d  = s_q;
            if (a_q != '0 && v > s_q) begin
              best_d = v;
            end
          end
        end else if (a_q != '0 && v > best_q) begin
          best_d = v;
          peak_d = t_q - {{(32-AgeW){1'b0}}, a_q};
        end
        if (a_q == '0) begin
          state_d = ST_S_END;
        end else begin
          a_d     = a_q - 1'b1;
          state_d = ST_S_RD;
        end
      end
      ST_S_END: begin
        if (found_q) begin
          if (cnt_q < CntW'(PENDING)) begin
            p_we_o = 1'b1;
            cnt_d  = cnt_q + 1'b1;
          end
          resume_d = t_q + 1'b1;
        end
        state_d = ST_PEEK;
      end
      ST_PEEK: begin
        if (cnt_q != '0) begin
          p_re_o  = 1'b1;
          state_d = ST_PCHK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PCHK: begin
        peak_d = p_rdata_i;
        d_d    = gap;
        j_d    = '0;
        state_d = (gap >= 32'(READY)) ? ST_E_RD : ST_IDLE;
      end
      ST_E_RD: begin
        h_re_o    = 1'b1;
        h_raddr_o = hist_idx(head_q, hage);
        zero_d    = (age >= {{(32-FillW){1'b0}}, fill_q});
        state_d   = ST_E_WR;
      end
      ST_E_WR: begin
        if (out_free_i) begin
          out_req_o.load        = 1'b1;
          out_req_o.spike_at    = peak_q;
          out_req_o.wave_sample = zero_q ? 16'sd0 : $signed(h_rdata_i);
          out_req_o.wave_slot   = j_q;
          out_req_o.last        = (j_q == 5'(SNIP - 1));
          if (j_q == 5'(SNIP - 1)) begin
            rd_d    = (rd_q == PendAw'(PENDING - 1)) ? '0 : rd_q + 1'b1;
            cnt_d   = cnt_q - 1'b1;
            state_d = ST_IDLE;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = ST_E_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pos_q    <= '0;
      resume_q <= '0;
      head_q   <= '0;
      fill_q   <= '0;
      cnt_q    <= '0;
      rd_q     <= '0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      resume_q <= resume_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      cnt_q    <= cnt_d;
      rd_q     <= rd_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    s_q    <= s_d;
    best_q <= best_d;
    a_q    <= a_d;
    zero_q <= zero_d;
    peak_q <= peak_d;
    d_q    <= d_d;
    j_q    <= j_d;
  end

endmodule

// ===== hw/rtl/dual_threshold_spike_detector_unit.sv =====
// ----------------------------------------------------------------------------
// dual_threshold_spike_detector_unit
// Dual-threshold spike detector with peak queue and snippet output.
// ----------------------------------------------------------------------------
// Sequencing: a sample that completes no spike and releases no snippet passes idle, the queue
//   peek and, with a peak queued, the pending check; a lower crossing adds a read and an
//   evaluate state per window position searched plus an end state, set by the single history
//   read port. A snippet adds a read and a write state per sample (SNIP samples) plus any stall.
// One request in flight at a time; the last result may wait in the output
//   register while the next request is taken.
// Reset clears counters, pointers and the fill count; history entries never
//   written read as zero, so no clearing pass is needed.
module dual_threshold_spike_detector_unit import dtsd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        spike_at_o,
  output logic signed [15:0] wave_sample_o,
  output logic [4:0]         wave_slot_o,
  output logic               last_of_spike_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);

  // configuration registers
  logic signed [15:0] upper_q, lower_q;
  logic [15:0]        skip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= UPPER_RST;
      lower_q <= LOWER_RST;
      skip_q  <= SKIP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_UPPER: upper_q <= $signed(cfg_data_i);
        CFG_LOWER: lower_q <= $signed(cfg_data_i);
        CFG_SKIP:  skip_q  <= cfg_data_i;
        CFG_NONE:  ;
        default:   ;
      endcase
    end
  end

  // memories: sample history ring and pending peak queue
  logic              h_we, h_re, p_we, p_re;
  logic [HistAw-1:0] h_waddr, h_raddr;
  logic [15:0]       h_wdata, h_rdata;
  logic [PendAw-1:0] p_waddr, p_raddr;
  logic [31:0]       p_wdata, p_rdata;

  dtsd_ram #(.Width(16), .Depth(HISTORY)) u_hist (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .re_i    (h_re),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  dtsd_ram #(.Width(32), .Depth(PENDING)) u_pend (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // output register: free when empty or being taken this cycle
  logic     out_valid_q, out_free;
  out_req_t req;
  logic [31:0]        spike_q;
  logic signed [15:0] wave_q;
  logic [4:0]         slot_q;
  logic               last_q;

  assign out_free = !out_valid_q || !out_stall_i;

  dtsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sample_i   (sample_i),
    .busy_o     (in_stall_o),
    .upper_i    (upper_q),
    .lower_i    (lower_q),
    .skip_i     (skip_q),
    .h_we_o     (h_we),
    .h_waddr_o  (h_waddr),
    .h_wdata_o  (h_wdata),
    .h_re_o     (h_re),
    .h_raddr_o  (h_raddr),
    .h_rdata_i  (h_rdata),
    .p_we_o     (p_we),
    .p_waddr_o  (p_waddr),
    .p_wdata_o  (p_wdata),
    .p_re_o     (p_re),
    .p_raddr_o  (p_raddr),
    .p_rdata_i  (p_rdata),
    .out_free_i (out_free),
    .out_req_o  (req)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.load) begin
      spike_q <= req.spike_at;
      wave_q  <= req.wave_sample;
      slot_q  <= req.wave_slot;
      last_q  <= req.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign spike_at_o      = spike_q;
  assign wave_sample_o   = wave_q;
  assign wave_slot_o     = slot_q;
  assign last_of_spike_o = last_q;

  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.load |-> out_free) else $error("result loaded over a waiting result");

  // an accepted request always occupies the sequencer the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("sequencer not busy");

  // end-of-snippet flag sits on the final slot only
  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_of_spike_o == (wave_slot_o == 5'(SNIP - 1))))
    else $error("last flag on wrong slot");

endmodule
